// File: rtl/dda_pkg.sv
// Shared types and constants for the DDA line rasteriser.
package dda_pkg;

	localparam int COORD_BITS = 6;
	localparam int COLOR_BITS = 32;

	typedef struct packed {
		logic [COORD_BITS-1:0] start_x;
		logic [COORD_BITS-1:0] start_y;
		logic [COORD_BITS-1:0] end_x;
		logic [COORD_BITS-1:0] end_y;
		logic [COLOR_BITS-1:0] line_color;
	} line_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] pixel_x;
		logic [COORD_BITS-1:0] pixel_y;
		logic [COLOR_BITS-1:0] pixel_color;
		logic                  last_pixel;
	} pixel_t;

	typedef struct packed {
		logic load;
		logic set_inc;
		logic advance;
	} axis_ctrl_t;

endpackage

// File: rtl/dda_line_rasterizer_unit.sv
// Top level of the DDA line rasteriser: sequencer, shared divider and output register.
//
//  channel  | signals                          | carries
//  ---------+----------------------------------+------------------------------
//  line     | line_valid, line_ready, line     | one segment and its colour
//  pixel    | pixel_valid, pixel_ready, pixel  | one pixel, last flag on final
//
//  A segment runs through the serial divider (x then y increment, one
//  quotient bit a cycle), then emits its pixels, one per cycle unless the output stalls.
//  Zero-length segments skip the divider and emit the start pixel only.
//  line_ready is high only while the sequencer is idle.
//  A stalled pixel holds in the output register; emission resumes when taken.
//  Reset clears the sequencer and the output valid.
module dda_line_rasterizer_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             line_valid,
	output logic             line_ready,
	input  dda_pkg::line_t   line,
	output logic             pixel_valid,
	input  logic             pixel_ready,
	output dda_pkg::pixel_t  pixel
);
	import dda_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_DIV_X = 4'b0010,
		ST_DIV_Y = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	state_t st_q, st_d;

	logic [COORD_BITS-1:0] ady_q;
	logic [COORD_BITS-1:0] steps_q;
	logic [COORD_BITS-1:0] remain_q;
	logic [COLOR_BITS-1:0] color_q;
	logic                  out_valid_q;
	pixel_t                pixel_q;

	logic                  line_fire;
	logic                  emit_fire;
	logic                  out_free;
	logic                  xneg, yneg;
	logic [COORD_BITS-1:0] adx, ady, steps;

	logic                  div_start;
	logic                  div_done;
	logic [COORD_BITS-1:0] div_dividend;
	logic [COORD_BITS-1:0] div_divisor;
	logic [FRAC_BITS:0]    div_quotient;

	axis_ctrl_t            x_ctrl, y_ctrl;
	logic [COORD_BITS-1:0] x_coord, y_coord;

	assign line_ready  = (st_q == ST_IDLE);
	assign line_fire   = line_valid && line_ready;
	assign out_free    = !out_valid_q || pixel_ready;
	assign emit_fire   = (st_q == ST_EMIT) && out_free;
	assign pixel_valid = out_valid_q;
	assign pixel       = pixel_q;

	assign xneg  = (line.end_x < line.start_x);
	assign yneg  = (line.end_y < line.start_y);
	assign adx   = xneg ? (line.start_x - line.end_x) : (line.end_x - line.start_x);
	assign ady   = yneg ? (line.start_y - line.end_y) : (line.end_y - line.start_y);
	assign steps = (adx > ady) ? adx : ady;

	assign div_start    = (line_fire && (steps != '0)) || ((st_q == ST_DIV_X) && div_done);
	assign div_dividend = (st_q == ST_IDLE) ? adx : ady_q;
	assign div_divisor  = (st_q == ST_IDLE) ? steps : steps_q;

	assign x_ctrl = '{load: line_fire,
		set_inc: (st_q == ST_DIV_X) && div_done,
		advance: emit_fire};
	assign y_ctrl = '{load: line_fire,
		set_inc: (st_q == ST_DIV_Y) && div_done,
		advance: emit_fire};

	dda_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	dda_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_x (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (x_ctrl),
		.start  (line.start_x),
		.neg    (xneg),
		.inc    (div_quotient),
		.coord  (x_coord)
	);

	dda_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_y (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (y_ctrl),
		.start  (line.start_y),
		.neg    (yneg),
		.inc    (div_quotient),
		.coord  (y_coord)
	);

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: begin
				if (line_fire) begin
					st_d = (steps == '0) ? ST_EMIT : ST_DIV_X;
				end
			end
			ST_DIV_X: begin
				if (div_done) begin
					st_d = ST_DIV_Y;
				end
			end
			ST_DIV_Y: begin
				if (div_done) begin
					st_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (emit_fire && (remain_q == COORD_BITS'(1))) begin
					st_d = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			out_valid_q <= 1'b0;
			remain_q    <= '0;
		end else begin
			st_q <= st_d;
			if (out_free) begin
				out_valid_q <= (st_q == ST_EMIT);
			end
			if (line_fire) begin
				remain_q <= (steps == '0) ? COORD_BITS'(1) : steps;
			end else if (emit_fire) begin
				remain_q <= remain_q - COORD_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (line_fire) begin
			ady_q   <= ady;
			steps_q <= steps;
			color_q <= line.line_color;
		end
		if (emit_fire) begin
			pixel_q <= '{pixel_x: x_coord,
				pixel_y: y_coord,
				pixel_color: color_q,
				last_pixel: (remain_q == COORD_BITS'(1))};
		end
	end

endmodule

// File: rtl/dda_div.sv
// Serial restoring divider: one quotient bit per cycle, shared by both axes.
module dda_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [dda_pkg::COORD_BITS-1:0] dividend,
	input  logic [dda_pkg::COORD_BITS-1:0] divisor,
	output logic                           done,
	output logic [FRAC_BITS:0]             quotient
);
	import dda_pkg::*;

	localparam int CW = $clog2(FRAC_BITS + 1);

	logic [COORD_BITS-1:0] rem_q;
	logic [COORD_BITS-1:0] div_q;
	logic [FRAC_BITS:0]    quo_q;
	logic [CW-1:0]         cnt_q;
	logic                  busy_q;

	logic                  first;
	logic [COORD_BITS:0]   trial;
	logic [COORD_BITS:0]   diff;
	logic                  ge;
	logic [COORD_BITS-1:0] rem_next;

	assign first    = (cnt_q == CW'(FRAC_BITS));
	assign trial    = first ? {1'b0, rem_q} : {rem_q, 1'b0};
	assign diff     = trial - {1'b0, div_q};
	assign ge       = (trial >= {1'b0, div_q});
	assign rem_next = ge ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
	assign quotient = {quo_q[FRAC_BITS-1:0], ge};
	assign done     = busy_q && (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(FRAC_BITS);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			div_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= quotient;
		end
	end

endmodule

// File: rtl/dda_axis.sv
// One axis of the rasteriser: fixed-point position, increment and rounding.
module dda_axis #(
	parameter int FRAC_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  dda_pkg::axis_ctrl_t            ctrl,
	input  logic [dda_pkg::COORD_BITS-1:0] start,
	input  logic                           neg,
	input  logic [FRAC_BITS:0]             inc,
	output logic [dda_pkg::COORD_BITS-1:0] coord
);
	import dda_pkg::*;

	localparam int PW = COORD_BITS + FRAC_BITS;
	localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

	logic [PW-1:0]      pos_q;
	logic [FRAC_BITS:0] inc_q;
	logic               neg_q;
	logic [PW-1:0]      inc_ext;
	logic [PW-1:0]      round_sum;

	assign inc_ext   = PW'(inc_q);
	assign round_sum = pos_q + HALF;
	assign coord     = round_sum[PW-1:FRAC_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			inc_q <= '0;
			neg_q <= 1'b0;
		end else if (ctrl.load) begin
			pos_q <= {start, {FRAC_BITS{1'b0}}};
			inc_q <= '0;
			neg_q <= neg;
		end else begin
			if (ctrl.set_inc) begin
				inc_q <= inc;
			end
			if (ctrl.advance) begin
				pos_q <= neg_q ? (pos_q - inc_ext) : (pos_q + inc_ext);
			end
		end
	end

endmodule

// File: tb/dda_line_rasterizer_unit_tb.sv
// Self-checking DDA line rasteriser tb: directed and random segments in, predicted pixels out.
`timescale 1ns / 1ps

module dda_line_rasterizer_unit_tb;
	import dda_pkg::*;

	localparam int FRAC_BITS = 16;
	localparam int HALF_STEP = 1 << (FRAC_BITS - 1);
	localparam int RANDOM_LINES = 390;
	localparam int IDLE_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 150;

	typedef struct {
		line_t seg;
		bit    drain;
	} line_job_t;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   line_valid = 1'b0;
	logic   line_ready;
	line_t  line = '0;
	logic   pixel_valid;
	logic   pixel_ready = 1'b0;
	pixel_t pixel;

	line_job_t pending_lines[$];
	pixel_t    expected_pixels[$];
	int        errors = 0;
	int        gap_left = 0;
	int        burst_left = 1;
	int        idle_cycles = 0;
	logic [5:0]  ready_phase = '0;
	logic [15:0] ready_pattern = 16'hffff;

	dda_line_rasterizer_unit #(
		.FRAC_BITS(FRAC_BITS)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.line_valid (line_valid),
		.line_ready (line_ready),
		.line       (line),
		.pixel_valid(pixel_valid),
		.pixel_ready(pixel_ready),
		.pixel      (pixel)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic logic [COORD_BITS-1:0] axis_pixel(logic [COORD_BITS-1:0] origin,
		logic neg, logic [COORD_BITS+FRAC_BITS-1:0] inc, int k);
		logic [31:0] base;
		logic [31:0] offset;
		logic [31:0] pos;
		base = 32'(origin) << FRAC_BITS;
		offset = 32'(inc) * 32'(k);
		if (neg)
			pos = (offset > base) ? 32'd0 : base - offset;
		else
			pos = base + offset;
		return COORD_BITS'((pos + HALF_STEP) >> FRAC_BITS);
	endfunction

	function automatic void rasterise_line(line_t seg);
		logic xneg;
		logic yneg;
		logic [COORD_BITS-1:0] adx;
		logic [COORD_BITS-1:0] ady;
		logic [COORD_BITS-1:0] steps;
		logic [COORD_BITS+FRAC_BITS-1:0] xinc;
		logic [COORD_BITS+FRAC_BITS-1:0] yinc;
		int count;
		pixel_t px;
		xneg = seg.end_x < seg.start_x;
		yneg = seg.end_y < seg.start_y;
		adx = xneg ? seg.start_x - seg.end_x : seg.end_x - seg.start_x;
		ady = yneg ? seg.start_y - seg.end_y : seg.end_y - seg.start_y;
		steps = (adx > ady) ? adx : ady;
		xinc = '0;
		yinc = '0;
		if (steps != 0) begin
			xinc = {adx, {FRAC_BITS{1'b0}}} / steps;
			yinc = {ady, {FRAC_BITS{1'b0}}} / steps;
		end
		count = (steps == 0) ? 1 : int'(steps);
		for (int k = 0; k < count; k++) begin
			px.pixel_x = axis_pixel(seg.start_x, xneg, xinc, k);
			px.pixel_y = axis_pixel(seg.start_y, yneg, yinc, k);
			px.pixel_color = seg.line_color;
			px.last_pixel = (k + 1 == count);
			expected_pixels.push_back(px);
		end
	endfunction

	task automatic queue_line(int sx, int sy, int ex, int ey, logic [COLOR_BITS-1:0] color,
		bit drain);
		line_job_t job;
		job.seg.start_x = COORD_BITS'(sx);
		job.seg.start_y = COORD_BITS'(sy);
		job.seg.end_x = COORD_BITS'(ex);
		job.seg.end_y = COORD_BITS'(ey);
		job.seg.line_color = color;
		job.drain = drain;
		pending_lines.push_back(job);
	endtask

	function automatic int clamp_coord(int v);
		int top;
		top = (1 << COORD_BITS) - 1;
		return (v < 0) ? 0 : (v > top) ? top : v;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		line_job_t job;
		if (!arst_n) begin
			line_valid <= 1'b0;
		end else begin
			if (line_valid && line_ready)
				rasterise_line(line);
			if (!line_valid || line_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					line_valid <= 1'b0;
				end else if (pending_lines.size() == 0 ||
						(pending_lines[0].drain && expected_pixels.size() != 0)) begin
					line_valid <= 1'b0;
				end else begin
					job = pending_lines.pop_front();
					line <= job.seg;
					line_valid <= 1'b1;
					burst_left--;
					if (burst_left == 0) begin
						if ($urandom_range(0, 5) == 0) begin
							burst_left = $urandom_range(10, 30);
							gap_left = 0;
						end else begin
							burst_left = $urandom_range(1, 6);
							gap_left = $urandom_range(0, 12);
						end
					end
				end
			end
		end
	end

	// receiver back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_ready <= 1'b0;
		end else begin
			if (ready_phase == 0) begin
				if ($urandom_range(0, 3) == 0)
					ready_pattern = 16'hffff;
				else
					ready_pattern = 16'($urandom) | (16'h1 << $urandom_range(0, 15));
			end
			pixel_ready <= ready_pattern[ready_phase[3:0]];
			ready_phase <= ready_phase + 1'b1;
		end
	end

	// monitor
	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && pixel_valid && pixel_ready) begin
			if (expected_pixels.size() == 0) begin
				$display("%0t: unexpected pixel transaction %p", $time, pixel);
				errors++;
			end else begin
				want = expected_pixels.pop_front();
				if (pixel.pixel_x !== want.pixel_x) begin
					$display("%0t: pixel_x expected %0d actual %0d", $time,
						want.pixel_x, pixel.pixel_x);
					errors++;
				end
				if (pixel.pixel_y !== want.pixel_y) begin
					$display("%0t: pixel_y expected %0d actual %0d", $time,
						want.pixel_y, pixel.pixel_y);
					errors++;
				end
				if (pixel.pixel_color !== want.pixel_color) begin
					$display("%0t: pixel_color expected %h actual %h", $time,
						want.pixel_color, pixel.pixel_color);
					errors++;
				end
				if (pixel.last_pixel !== want.last_pixel) begin
					$display("%0t: last_pixel expected %b actual %b", $time,
						want.last_pixel, pixel.last_pixel);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (line_valid && line_ready) || (pixel_valid && pixel_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		int top;
		int sx;
		int sy;
		int ex;
		int ey;
		int len;
		top = (1 << COORD_BITS) - 1;

		queue_line(0, 0, 0, 0, 32'h0000_0000, 1'b0);
		queue_line(top, top, top, top, 32'hffff_ffff, 1'b0);
		queue_line(10, 10, 11, 10, 32'h1234_5678, 1'b0);
		queue_line(10, 10, 10, 9, 32'h8765_4321, 1'b0);
		queue_line(5, 5, 6, 6, 32'hdead_beef, 1'b0);
		queue_line(0, 0, top, 0, 32'haaaa_aaaa, 1'b0);
		queue_line(top, 0, 0, 0, 32'h5555_5555, 1'b0);
		queue_line(0, 0, 0, top, 32'hffff_0000, 1'b0);
		queue_line(0, top, 0, 0, 32'h0000_ffff, 1'b0);
		queue_line(0, 0, top, top, 32'hff00_ff00, 1'b0);
		queue_line(top, top, 0, 0, 32'h00ff_00ff, 1'b1);
		queue_line(0, top, top, 0, 32'hf0f0_f0f0, 1'b0);
		queue_line(top, 0, 0, top, 32'h0f0f_0f0f, 1'b0);
		queue_line(20, 20, 40, 27, 32'h0102_0304, 1'b0);
		queue_line(20, 20, 27, 40, 32'h0506_0708, 1'b0);
		queue_line(20, 20, 0, 13, 32'h090a_0b0c, 1'b0);
		queue_line(20, 20, 13, 0, 32'h0d0e_0f10, 1'b0);
		queue_line(20, 20, 40, 13, 32'h1112_1314, 1'b0);
		queue_line(20, 20, 13, 40, 32'h1516_1718, 1'b0);
		// half-way positions round up
		queue_line(0, 0, 2, 1, 32'hcafe_f00d, 1'b0);
		queue_line(0, 1, 2, 0, 32'hbead_feed, 1'b0);
		queue_line(0, 0, top, top - 1, 32'h7fff_ffff, 1'b1);

		for (int i = 0; i < RANDOM_LINES; i++) begin
			sx = $urandom_range(0, top);
			sy = $urandom_range(0, top);
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					ex = $urandom_range(0, top);
					ey = $urandom_range(0, top);
				end
				4, 5: begin
					ex = clamp_coord(sx + $urandom_range(0, 8) - 4);
					ey = clamp_coord(sy + $urandom_range(0, 8) - 4);
				end
				6: begin
					ex = $urandom_range(0, 1) ? sx : $urandom_range(0, top);
					ey = (ex == sx) ? $urandom_range(0, top) : sy;
				end
				7: begin
					len = $urandom_range(0, top);
					ex = clamp_coord($urandom_range(0, 1) ? sx + len : sx - len);
					ey = clamp_coord($urandom_range(0, 1) ? sy + len : sy - len);
				end
				8: begin
					ex = sx;
					ey = sy;
				end
				default: begin
					sx = $urandom_range(0, 1) * top;
					sy = $urandom_range(0, 1) * top;
					ex = $urandom_range(0, 1) * top;
					ey = $urandom_range(0, 1) * top;
				end
			endcase
			queue_line(sx, sy, ex, ey, $urandom, $urandom_range(0, 39) == 0);
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		do @(posedge clk);
		while (pending_lines.size() != 0 || line_valid || expected_pixels.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (expected_pixels.size() != 0) begin
			$display("%0t: %0d expected pixels never arrived", $time, expected_pixels.size());
			errors++;
		end
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// File: sim.f
rtl/dda_pkg.sv
rtl/dda_div.sv
rtl/dda_axis.sv
rtl/dda_line_rasterizer_unit.sv
tb/dda_line_rasterizer_unit_tb.sv
